// File: rtl/core/ppcr_pkg.sv
// Shared types, constants and helpers for the particle pair collision resolver.
package ppcr_pkg;

  localparam int POS_W        = 24;
  localparam int RAD_W        = 16;
  localparam int DAMP_W       = 17;
  localparam int DAMP_FRAC    = 16;
  localparam int POS_FRAC_DEF = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int SAT_W        = 40;

  localparam logic [DAMP_W-1:0] DAMP_ONE   = DAMP_W'(65536);
  localparam logic [DAMP_W-1:0] DAMP_RESET = DAMP_W'(65470);

  localparam logic signed [SAT_W-1:0] POS_MAX = SAT_W'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] POS_MIN = -POS_MAX - SAT_W'(1);

  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    ST_NONE       = 2'd0,
    ST_RESOLVED   = 2'd1,
    ST_COINCIDENT = 2'd2
  } status_t;

  typedef struct packed {
    pos_t             first_pos_x;
    pos_t             first_pos_y;
    pos_t             first_prev_x;
    pos_t             first_prev_y;
    logic [RAD_W-1:0] first_radius;
    pos_t             second_pos_x;
    pos_t             second_pos_y;
    pos_t             second_prev_x;
    pos_t             second_prev_y;
    logic [RAD_W-1:0] second_radius;
  } in_t;

  typedef struct packed {
    pos_t    new_first_pos_x;
    pos_t    new_first_pos_y;
    pos_t    new_first_prev_x;
    pos_t    new_first_prev_y;
    pos_t    new_second_pos_x;
    pos_t    new_second_pos_y;
    pos_t    new_second_prev_x;
    pos_t    new_second_prev_y;
    status_t contact_status;
  } out_t;

  function automatic pos_t sat_pos(input logic signed [SAT_W-1:0] x);
    pos_t r;
    if (x > POS_MAX) begin
      r = POS_MAX[POS_W-1:0];
    end else if (x < POS_MIN) begin
      r = POS_MIN[POS_W-1:0];
    end else begin
      r = x[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/ppcr_front.sv
// Front end: differences, radius sum and the exact contact test.
module ppcr_front
  import ppcr_pkg::*;
#(
  parameter int POS_FRAC_BITS = POS_FRAC_DEF,
  localparam int RS_W = POS_FRAC_BITS + 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output in_t               out_pl,
  output logic [RS_W-1:0]   out_ax,
  output logic [RS_W-1:0]   out_ay,
  output logic              out_sx,
  output logic              out_sy,
  output logic [RS_W-1:0]   out_rs,
  output logic [2*RS_W-1:0] out_d2,
  output status_t           out_status
);

  localparam int DX_W  = POS_W + 1;
  localparam int CMP_W = (DX_W > RS_W) ? DX_W : RS_W;
  localparam int SQ_W  = 2 * RS_W;

  logic en;
  logic v1, v2, v3, v4;

  assign en       = !v4 || out_ready;
  assign in_ready = en;

  // Stage 1: center differences and radius sum in position format.
  in_t                    pl1;
  logic signed [DX_W-1:0] dx1, dy1;
  logic [RS_W-1:0]        rs1;
  logic [RAD_W:0]         rsum;
  logic [RS_W-1:0]        rs_c;

  assign rsum = {1'b0, in_data.first_radius} + {1'b0, in_data.second_radius};

  generate
    if (POS_FRAC_BITS >= 8) begin : g_up
      assign rs_c = RS_W'(rsum) << (POS_FRAC_BITS - 8);
    end else begin : g_dn
      localparam int SH = 8 - POS_FRAC_BITS;
      logic [RAD_W+1:0] rnd;
      assign rnd  = {1'b0, rsum} + (RAD_W + 2)'(1 << (SH - 1));
      assign rs_c = RS_W'(rnd >> SH);
    end
  endgenerate

  // Stage 2: magnitudes and the box test against the radius sum.
  in_t                  pl2;
  logic [RS_W-1:0]      ax2, ay2, rs2;
  logic                 sx2, sy2, inr2;
  logic signed [DX_W:0] dxe, dye;
  logic [DX_W-1:0]      axf, ayf;
  logic [CMP_W-1:0]     axc, ayc, rsc;

  assign dxe = (DX_W + 1)'(dx1);
  assign dye = (DX_W + 1)'(dy1);
  assign axf = dx1[DX_W-1] ? DX_W'(-dxe) : DX_W'(dxe);
  assign ayf = dy1[DX_W-1] ? DX_W'(-dye) : DX_W'(dye);
  assign axc = CMP_W'(axf);
  assign ayc = CMP_W'(ayf);
  assign rsc = CMP_W'(rs1);

  // Stage 3: squares.
  in_t             pl3;
  logic [RS_W-1:0] ax3, ay3, rs3;
  logic            sx3, sy3, inr3;
  logic [SQ_W-1:0] sqx3, sqy3, rsq3;

  // Stage 4: squared distance against squared radius sum.
  logic [SQ_W:0] d2sum;
  assign d2sum = (SQ_W + 1)'(sqx3) + (SQ_W + 1)'(sqy3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl1  <= in_data;
      dx1  <= DX_W'(in_data.first_pos_x) - DX_W'(in_data.second_pos_x);
      dy1  <= DX_W'(in_data.first_pos_y) - DX_W'(in_data.second_pos_y);
      rs1  <= rs_c;

      pl2  <= pl1;
      ax2  <= axc[RS_W-1:0];
      ay2  <= ayc[RS_W-1:0];
      sx2  <= dx1[DX_W-1];
      sy2  <= dy1[DX_W-1];
      rs2  <= rs1;
      inr2 <= (axc < rsc) && (ayc < rsc);

      pl3  <= pl2;
      ax3  <= ax2;
      ay3  <= ay2;
      sx3  <= sx2;
      sy3  <= sy2;
      rs3  <= rs2;
      inr3 <= inr2;
      sqx3 <= SQ_W'(ax2) * SQ_W'(ax2);
      sqy3 <= SQ_W'(ay2) * SQ_W'(ay2);
      rsq3 <= SQ_W'(rs2) * SQ_W'(rs2);

      out_pl <= pl3;
      out_ax <= ax3;
      out_ay <= ay3;
      out_sx <= sx3;
      out_sy <= sy3;
      out_rs <= rs3;
      out_d2 <= d2sum[SQ_W-1:0];
      if (inr3 && (d2sum < (SQ_W + 1)'(rsq3))) begin
        out_status <= (d2sum == '0) ? ST_COINCIDENT : ST_RESOLVED;
      end else begin
        out_status <= ST_NONE;
      end
    end
  end

  assign out_valid = v4;

endmodule

// File: rtl/core/ppcr_fifo.sv
// Small register queue between the front end and the back end.
module ppcr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic          push, pop;

  assign push_ready = cnt != (AW + 1)'(DEPTH);
  assign pop_valid  = cnt != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

endmodule

// File: rtl/core/ppcr_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module ppcr_isqrt #(
  parameter int Q      = 22,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*Q-1:0]    n,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q-1:0]      root,
  output logic [SIDE_W-1:0] out_side
);

  logic              vq  [Q];
  logic [2*Q-1:0]    nq  [Q];
  logic [Q+1:0]      rem [Q];
  logic [Q-1:0]      rt  [Q];
  logic [SIDE_W-1:0] sd  [Q];

  for (genvar g = 0; g < Q; g++) begin : g_stage
    logic              vi;
    logic [2*Q-1:0]    ni;
    logic [Q+1:0]      ri;
    logic [Q-1:0]      rti;
    logic [SIDE_W-1:0] si;
    logic [Q+3:0]      rem_n, trial, diff;

    if (g == 0) begin : g_first
      assign vi  = in_valid;
      assign ni  = n;
      assign ri  = '0;
      assign rti = '0;
      assign si  = in_side;
    end else begin : g_next
      assign vi  = vq[g-1];
      assign ni  = nq[g-1];
      assign ri  = rem[g-1];
      assign rti = rt[g-1];
      assign si  = sd[g-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_n = {ri, ni[2*Q-1 -: 2]};
    assign trial = {2'b00, rti, 2'b01};
    assign diff  = rem_n - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[g] <= 1'b0;
      end else if (en) begin
        vq[g] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq[g] <= ni << 2;
        sd[g] <= si;
        if (rem_n >= trial) begin
          rem[g] <= diff[Q+1:0];
          rt[g]  <= {rti[Q-2:0], 1'b1};
        end else begin
          rem[g] <= rem_n[Q+1:0];
          rt[g]  <= {rti[Q-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vq[Q-1];
  assign root      = rt[Q-1];
  assign out_side  = sd[Q-1];

endmodule

// File: rtl/core/ppcr_div.sv
// Pipelined restoring divider for two dividends over one shared divisor.
module ppcr_div #(
  parameter int QD     = 18,
  parameter int DVW    = 27,
  parameter int NW     = 42,
  parameter int SIDE_W = 8,
  localparam int DW = DVW + QD
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NW-1:0]     num_x,
  input  logic [NW-1:0]     num_y,
  input  logic [DVW-1:0]    den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QD-1:0]     quo_x,
  output logic [QD-1:0]     quo_y,
  output logic [SIDE_W-1:0] out_side
);

  logic              vq [QD];
  logic [DW-1:0]     rx [QD];
  logic [DW-1:0]     ry [QD];
  logic [DVW-1:0]    dv [QD];
  logic [QD-1:0]     qx [QD];
  logic [QD-1:0]     qy [QD];
  logic [SIDE_W-1:0] sd [QD];

  for (genvar g = 0; g < QD; g++) begin : g_stage
    localparam int J = QD - 1 - g;
    logic              vi;
    logic [DW-1:0]     rxi, ryi, t;
    logic [DVW-1:0]    di;
    logic [QD-1:0]     qxi, qyi;
    logic [SIDE_W-1:0] si;

    if (g == 0) begin : g_first
      assign vi  = in_valid;
      assign rxi = DW'(num_x);
      assign ryi = DW'(num_y);
      assign di  = den;
      assign qxi = '0;
      assign qyi = '0;
      assign si  = in_side;
    end else begin : g_next
      assign vi  = vq[g-1];
      assign rxi = rx[g-1];
      assign ryi = ry[g-1];
      assign di  = dv[g-1];
      assign qxi = qx[g-1];
      assign qyi = qy[g-1];
      assign si  = sd[g-1];
    end

    assign t = DW'(di) << J;

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[g] <= 1'b0;
      end else if (en) begin
        vq[g] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[g] <= di;
        sd[g] <= si;
        if (rxi >= t) begin
          rx[g] <= rxi - t;
          qx[g] <= {qxi[QD-2:0], 1'b1};
        end else begin
          rx[g] <= rxi;
          qx[g] <= {qxi[QD-2:0], 1'b0};
        end
        if (ryi >= t) begin
          ry[g] <= ryi - t;
          qy[g] <= {qyi[QD-2:0], 1'b1};
        end else begin
          ry[g] <= ryi;
          qy[g] <= {qyi[QD-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vq[QD-1];
  assign quo_x     = qx[QD-1];
  assign quo_y     = qy[QD-1];
  assign out_side  = sd[QD-1];

endmodule

// File: rtl/core/ppcr_back.sv
// Back end: distance, push-apart offsets, damping and the output register.
module ppcr_back
  import ppcr_pkg::*;
#(
  parameter int POS_FRAC_BITS = POS_FRAC_DEF,
  localparam int RS_W = POS_FRAC_BITS + 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_pl,
  input  logic [RS_W-1:0]   in_ax,
  input  logic [RS_W-1:0]   in_ay,
  input  logic              in_sx,
  input  logic              in_sy,
  input  logic [RS_W-1:0]   in_rs,
  input  logic [2*RS_W-1:0] in_d2,
  input  logic [1:0]        in_status,
  input  logic [DAMP_W-1:0] dmp,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data
);

  localparam int Q    = RS_W + 5;
  localparam int IN_W = $bits(in_t);
  localparam int S1_W = IN_W + 3 * RS_W + 4;
  localparam int S2_W = IN_W + 4;
  localparam int DVW  = Q + 4;
  localparam int PXW  = RS_W + Q;
  localparam int NW   = PXW + 1;
  localparam int MW   = POS_W + 1;
  localparam int PW   = MW + DAMP_W;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Distance with five extra fraction bits.
  logic              sq_v;
  logic [Q-1:0]      dq;
  logic [S1_W-1:0]   sq_side;
  in_t               s_pl;
  logic [RS_W-1:0]   s_ax, s_ay, s_rs;
  logic              s_sx, s_sy;
  logic [1:0]        s_st;

  ppcr_isqrt #(.Q(Q), .SIDE_W(S1_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .n         ({in_d2, 10'b0}),
    .in_side   ({in_pl, in_ax, in_ay, in_sx, in_sy, in_rs, in_status}),
    .out_valid (sq_v),
    .root      (dq),
    .out_side  (sq_side)
  );

  assign {s_pl, s_ax, s_ay, s_sx, s_sy, s_rs, s_st} = sq_side;

  // Overlap, divisor 10*dq and rounding term 5*dq, then the dividends.
  logic              m0v, m1v, m2v;
  in_t               pl0, pl1, pl2m;
  logic [RS_W-1:0]   ax0, ay0;
  logic [Q-1:0]      ov0;
  logic [DVW-1:0]    den0, den1, den2, half0, half1;
  logic              sx0, sy0, sx1, sy1, sx2, sy2;
  logic [1:0]        st0, st1, st2m;
  logic [PXW-1:0]    px1, py1;
  logic [NW-1:0]     nx2, ny2;

  always_ff @(posedge clk) begin
    if (en) begin
      pl0   <= s_pl;
      ax0   <= s_ax;
      ay0   <= s_ay;
      sx0   <= s_sx;
      sy0   <= s_sy;
      st0   <= s_st;
      ov0   <= {s_rs, 5'b0} - dq;
      den0  <= (DVW'(dq) << 3) + (DVW'(dq) << 1);
      half0 <= (DVW'(dq) << 2) + DVW'(dq);

      pl1   <= pl0;
      sx1   <= sx0;
      sy1   <= sy0;
      st1   <= st0;
      den1  <= den0;
      half1 <= half0;
      px1   <= PXW'(ax0) * PXW'(ov0);
      py1   <= PXW'(ay0) * PXW'(ov0);

      pl2m  <= pl1;
      sx2   <= sx1;
      sy2   <= sy1;
      st2m  <= st1;
      den2  <= den1;
      nx2   <= NW'(px1) + NW'(half1);
      ny2   <= NW'(py1) + NW'(half1);
    end
  end

  logic            dv_v;
  logic [RS_W-1:0] qx, qy;
  logic [S2_W-1:0] dv_side;
  in_t             d_pl;
  logic            d_sx, d_sy;
  logic [1:0]      d_st;

  ppcr_div #(.QD(RS_W), .DVW(DVW), .NW(NW), .SIDE_W(S2_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m2v),
    .num_x     (nx2),
    .num_y     (ny2),
    .den       (den2),
    .in_side   ({pl2m, sx2, sy2, st2m}),
    .out_valid (dv_v),
    .quo_x     (qx),
    .quo_y     (qy),
    .out_side  (dv_side)
  );

  assign {d_pl, d_sx, d_sy, d_st} = dv_side;

  // Element order: first x, first y, second x, second y.
  logic signed [SAT_W-1:0] oxe, oye;
  logic signed [SAT_W-1:0] new_sum [4];
  pos_t                    prev_a  [4];

  assign oxe = d_sx ? -SAT_W'(qx) : SAT_W'(qx);
  assign oye = d_sy ? -SAT_W'(qy) : SAT_W'(qy);

  assign new_sum[0] = SAT_W'(d_pl.first_pos_x) + oxe;
  assign new_sum[1] = SAT_W'(d_pl.first_pos_y) + oye;
  assign new_sum[2] = SAT_W'(d_pl.second_pos_x) - oxe;
  assign new_sum[3] = SAT_W'(d_pl.second_pos_y) - oye;

  logic       p0v, p1v, p2v;
  in_t        pp0, pp1, pp2;
  logic [1:0] ps0, ps1, ps2;
  pos_t       rn0 [4];
  pos_t       rn1 [4];
  pos_t       rn2 [4];
  logic [MW-1:0] mag1 [4];
  logic          sg1  [4];
  logic          sg2  [4];
  logic [PW-1:0] prod2 [4];

  assign prev_a[0] = pp0.first_prev_x;
  assign prev_a[1] = pp0.first_prev_y;
  assign prev_a[2] = pp0.second_prev_x;
  assign prev_a[3] = pp0.second_prev_y;

  logic signed [SAT_W-1:0] vel  [4];
  logic signed [SAT_W-1:0] vabs [4];
  logic [PW:0]             vdm  [4];
  logic signed [SAT_W-1:0] vd   [4];
  pos_t                    np   [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vel[i]  = SAT_W'(rn0[i]) - SAT_W'(prev_a[i]);
      vabs[i] = vel[i][SAT_W-1] ? -vel[i] : vel[i];
      vdm[i]  = ((PW + 1)'(prod2[i]) + (PW + 1)'(1 << (DAMP_FRAC - 1))) >> DAMP_FRAC;
      vd[i]   = sg2[i] ? -SAT_W'(vdm[i]) : SAT_W'(vdm[i]);
      np[i]   = sat_pos(SAT_W'(rn2[i]) - vd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp0 <= d_pl;
      ps0 <= d_st;
      pp1 <= pp0;
      ps1 <= ps0;
      pp2 <= pp1;
      ps2 <= ps1;
      for (int i = 0; i < 4; i++) begin
        rn0[i]   <= sat_pos(new_sum[i]);
        rn1[i]   <= rn0[i];
        mag1[i]  <= vabs[i][MW-1:0];
        sg1[i]   <= vel[i][SAT_W-1];
        rn2[i]   <= rn1[i];
        sg2[i]   <= sg1[i];
        prod2[i] <= PW'(mag1[i]) * PW'(dmp);
      end

      // Only a resolved contact changes the positions.
      if (status_t'(ps2) == ST_RESOLVED) begin
        out_data.new_first_pos_x   <= rn2[0];
        out_data.new_first_pos_y   <= rn2[1];
        out_data.new_first_prev_x  <= np[0];
        out_data.new_first_prev_y  <= np[1];
        out_data.new_second_pos_x  <= rn2[2];
        out_data.new_second_pos_y  <= rn2[3];
        out_data.new_second_prev_x <= np[2];
        out_data.new_second_prev_y <= np[3];
      end else begin
        out_data.new_first_pos_x   <= pp2.first_pos_x;
        out_data.new_first_pos_y   <= pp2.first_pos_y;
        out_data.new_first_prev_x  <= pp2.first_prev_x;
        out_data.new_first_prev_y  <= pp2.first_prev_y;
        out_data.new_second_pos_x  <= pp2.second_pos_x;
        out_data.new_second_pos_y  <= pp2.second_pos_y;
        out_data.new_second_prev_x <= pp2.second_prev_x;
        out_data.new_second_prev_y <= pp2.second_prev_y;
      end
      out_data.contact_status <= status_t'(ps2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m0v       <= 1'b0;
      m1v       <= 1'b0;
      m2v       <= 1'b0;
      p0v       <= 1'b0;
      p1v       <= 1'b0;
      p2v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m0v       <= sq_v;
      m1v       <= m0v;
      m2v       <= m1v;
      p0v       <= dv_v;
      p1v       <= p0v;
      p2v       <= p1v;
      out_valid <= p2v;
    end
  end

endmodule

// File: rtl/core/particle_pair_collision_resolve_core.sv
// Particle pair collision resolver: one pair per cycle when the output is not stalled, fully pipelined.
// A pair passes through four front stages, the queue, one square root stage and one divider stage
// per result bit, and seven stages of offset, damping and output logic. Throughput is one pair
// per cycle while out_ready does not stall the output.
// Synchronous reset empties the pipeline and queue and sets the damping register to 65470.
module particle_pair_collision_resolve_core
  import ppcr_pkg::*;
#(
  parameter int POS_FRAC_BITS = POS_FRAC_DEF,
  parameter int FIFO_DEPTH    = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [DAMP_W-1:0] cfg_wdata
);

  localparam int RS_W = POS_FRAC_BITS + 10;
  localparam int QW   = $bits(in_t) + 5 * RS_W + 4;

  logic [DAMP_W-1:0] damping;
  logic [DAMP_W-1:0] dmp;

  always_ff @(posedge clk) begin
    if (rst) begin
      damping <= DAMP_RESET;
    end else if (cfg_we) begin
      damping <= cfg_wdata;
    end
  end

  // Values above one act as one.
  assign dmp = (damping > DAMP_ONE) ? DAMP_ONE : damping;

  logic              f_valid, f_ready;
  in_t               f_pl, b_pl;
  logic [RS_W-1:0]   f_ax, f_ay, f_rs, b_ax, b_ay, b_rs;
  logic              f_sx, f_sy, b_sx, b_sy;
  logic [2*RS_W-1:0] f_d2, b_d2;
  status_t           f_st;
  logic [1:0]        b_st;
  logic              b_valid, b_ready;
  logic [QW-1:0]     q_out;

  ppcr_front #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_pl     (f_pl),
    .out_ax     (f_ax),
    .out_ay     (f_ay),
    .out_sx     (f_sx),
    .out_sy     (f_sy),
    .out_rs     (f_rs),
    .out_d2     (f_d2),
    .out_status (f_st)
  );

  ppcr_fifo #(.W(QW), .DEPTH(FIFO_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_pl, f_ax, f_ay, f_sx, f_sy, f_rs, f_d2, f_st}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (q_out)
  );

  assign {b_pl, b_ax, b_ay, b_sx, b_sy, b_rs, b_d2, b_st} = q_out;

  ppcr_back #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_pl     (b_pl),
    .in_ax     (b_ax),
    .in_ay     (b_ay),
    .in_sx     (b_sx),
    .in_sy     (b_sy),
    .in_rs     (b_rs),
    .in_d2     (b_d2),
    .in_status (b_st),
    .dmp       (dmp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/ppcr_checker.sv
// Port-level checks for the collision resolver, bound to the top level.
module ppcr_checker
  import ppcr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // Pairs accepted but not yet delivered.
  logic [15:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 16'(in_valid && in_ready) - 16'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cnt != '0)
    else $error("result beat without an outstanding pair");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind particle_pair_collision_resolve_core ppcr_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: bench/testbench.sv
// Self-checking bench for the particle pair collision resolver core.
module testbench;
  import ppcr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class collision_board;
    logic [DAMP_W-1:0] damping;
    out_t              pending[$];
    int                errors;
    int                matched;
    int                n_resolved;
    int                n_coincident;

    function new();
      damping = DAMP_RESET;
      errors = 0;
      matched = 0;
      n_resolved = 0;
      n_coincident = 0;
    endfunction

    function longint clamp_pos(longint x);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (POS_W - 1)) - 1;
      lo = -(64'sd1 <<< (POS_W - 1));
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
    endfunction

    // Scaled product with rounding to nearest, ties away from zero.
    function longint scale_round(longint a, longint b, longint d);
      longint m;
      longint q;
      m = (a < 0) ? -a : a;
      q = (m * b + d / 2) / d;
      return (a < 0) ? -q : q;
    endfunction

    function longint int_sqrt(longint n);
      longint res;
      longint bitv;
      res = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > n) bitv = bitv >>> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >>> 1) + bitv;
        end else begin
          res = res >>> 1;
        end
        bitv = bitv >>> 2;
      end
      return res;
    endfunction

    function void note_pair(in_t b);
      longint p[8];
      longint r[8];
      longint rs, dx, dy, ax, ay, d2, dq, ov, ox, oy, dmp, vx, vy;
      out_t e;
      p[0] = b.first_pos_x;   p[1] = b.first_pos_y;
      p[2] = b.first_prev_x;  p[3] = b.first_prev_y;
      p[4] = b.second_pos_x;  p[5] = b.second_pos_y;
      p[6] = b.second_prev_x; p[7] = b.second_prev_y;
      for (int i = 0; i < 8; i++) r[i] = p[i];
      e.contact_status = ST_NONE;
      rs = longint'(b.first_radius) + longint'(b.second_radius);
      dx = p[0] - p[4];
      dy = p[1] - p[5];
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax < rs && ay < rs) begin
        d2 = ax * ax + ay * ay;
        if (d2 < rs * rs) begin
          if (d2 == 0) begin
            e.contact_status = ST_COINCIDENT;
          end else begin
            dmp = (damping > DAMP_ONE) ? longint'(DAMP_ONE) : longint'(damping);
            dq = int_sqrt(d2 * 1024);
            ov = rs * 32 - dq;
            ox = scale_round(dx, ov, 10 * dq);
            oy = scale_round(dy, ov, 10 * dq);
            e.contact_status = ST_RESOLVED;
            r[0] = clamp_pos(p[0] + ox);
            r[1] = clamp_pos(p[1] + oy);
            r[4] = clamp_pos(p[4] - ox);
            r[5] = clamp_pos(p[5] - oy);
            for (int k = 0; k < 8; k += 4) begin
              vx = r[k] - p[k+2];
              vy = r[k+1] - p[k+3];
              r[k+2] = clamp_pos(r[k] - scale_round(vx, dmp, 65536));
              r[k+3] = clamp_pos(r[k+1] - scale_round(vy, dmp, 65536));
            end
          end
        end
      end
      e.new_first_pos_x   = r[0][POS_W-1:0];
      e.new_first_pos_y   = r[1][POS_W-1:0];
      e.new_first_prev_x  = r[2][POS_W-1:0];
      e.new_first_prev_y  = r[3][POS_W-1:0];
      e.new_second_pos_x  = r[4][POS_W-1:0];
      e.new_second_pos_y  = r[5][POS_W-1:0];
      e.new_second_prev_x = r[6][POS_W-1:0];
      e.new_second_prev_y = r[7][POS_W-1:0];
      if (e.contact_status == ST_RESOLVED) n_resolved++;
      if (e.contact_status == ST_COINCIDENT) n_coincident++;
      pending = {pending, e};
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        $display("%0t: mismatch expected %h actual %h", $realtime, e, got);
        errors++;
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_we = 1'b0;
  logic [DAMP_W-1:0] cfg_wdata = '0;

  localparam int LATENCY = 2 * POS_FRAC_DEF + 36;

  collision_board board = new();
  int  send_idle_pct = 37;
  int  recv_idle_pct = 85;
  int  hold_off = 0;
  bit  sending_done = 1'b0;

  always #1 clk = ~clk;

  particle_pair_collision_resolve_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    #2000000;
    $display("** particle_pair_collision_resolve_core: FAILED **");
    $finish;
  end

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) board.check_result(out_data);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic pos_t rand_pos();
    case ($urandom_range(5))
      0: return pos_t'(24'sh7fffff);
      1: return pos_t'(24'sh800000);
      default: return pos_t'($urandom);
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] rand_rad();
    case ($urandom_range(4))
      0: return '1;
      1: return '0;
      default: return RAD_W'($urandom);
    endcase
  endfunction

  // Pairs close enough to touch most of the time, drawn near a random center.
  function automatic in_t rand_pair();
    in_t b;
    int  sel;
    sel = $urandom_range(9);
    b.first_pos_x = rand_pos();
    b.first_pos_y = rand_pos();
    b.first_prev_x = rand_pos();
    b.first_prev_y = rand_pos();
    b.second_prev_x = rand_pos();
    b.second_prev_y = rand_pos();
    b.first_radius = rand_rad();
    b.second_radius = rand_rad();
    if (sel < 2) begin
      b.second_pos_x = rand_pos();
      b.second_pos_y = rand_pos();
    end else if (sel == 2) begin
      b.second_pos_x = b.first_pos_x;
      b.second_pos_y = b.first_pos_y;
    end else begin
      b.second_pos_x = b.first_pos_x + pos_t'($signed($urandom_range(2 * 4096)) - 4096);
      b.second_pos_y = b.first_pos_y + pos_t'($signed($urandom_range(2 * 4096)) - 4096);
      if ($urandom_range(1)) begin
        b.first_prev_x = b.first_pos_x + pos_t'($signed($urandom_range(512)) - 256);
        b.first_prev_y = b.first_pos_y + pos_t'($signed($urandom_range(512)) - 256);
        b.second_prev_x = b.second_pos_x + pos_t'($signed($urandom_range(512)) - 256);
        b.second_prev_y = b.second_pos_y + pos_t'($signed($urandom_range(512)) - 256);
      end
    end
    return b;
  endfunction

  // Valid stays high between back-to-back beats; it drops only for idle cycles.
  task automatic send_pair(in_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_pair(b);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_damping(logic [DAMP_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.damping = v;
    @(posedge clk);
  endtask

  task automatic directed_pairs();
    in_t b;
    b = '0;
    send_pair(b);                                    // zero radii, same center
    b.first_radius = 16'd256;
    send_pair(b);                                    // coincident centers
    b.second_pos_x = 24'sd100;
    b.second_radius = 16'hffff;
    send_pair(b);                                    // resolved contact
    b.first_pos_x = 24'sh7fffff; b.second_pos_x = 24'sh7fff00;
    b.first_prev_x = 24'sh800000; b.second_prev_x = 24'sh7fffff;
    send_pair(b);                                    // push saturates high
    b.first_pos_x = 24'sh800000; b.second_pos_x = 24'sh800100;
    b.first_prev_x = 24'sh7fffff; b.second_prev_y = 24'sh800000;
    send_pair(b);                                    // push saturates low
    b = '0;
    b.first_pos_y = 24'sd10; b.first_radius = 16'd5;
    send_pair(b);                                    // out of reach
    b.first_pos_y = 24'sd1; b.first_prev_y = 24'sh7fffff; b.second_prev_y = 24'sh800000;
    send_pair(b);
    for (int i = 0; i < 10; i++) send_pair(rand_pair());
  endtask

  initial begin
    logic [DAMP_W-1:0] settings[4];
    settings[0] = DAMP_ONE; settings[1] = '0;
    settings[2] = '1; settings[3] = DAMP_W'(32768);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_pairs();
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end else if (ph % 2 == 0) begin
        send_idle_pct = 37; recv_idle_pct = 85;
      end else begin
        send_idle_pct = 85; recv_idle_pct = 37;
      end
      if (ph == 4) hold_off = 300;
      for (int i = 0; i < 240; i++) send_pair(rand_pair());
      drain();
      if (ph < 4) write_damping(settings[ph]);
    end
    send_idle_pct = 0; recv_idle_pct = 0;
    write_damping(DAMP_W'($urandom_range(65536)));
    for (int i = 0; i < 40; i++) send_pair(rand_pair());
    drain();
    $display("Checked %0d results (%0d resolved contacts, %0d coincident pairs)",
             board.matched, board.n_resolved, board.n_coincident);
    $display("over six damping settings, with stalls on both sides and a long output hold-off.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("** particle_pair_collision_resolve_core: PASSED **");
    end else begin
      $display("** particle_pair_collision_resolve_core: FAILED **");
    end
    $finish;
  end
endmodule
